@@ src/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CTRL     = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
  localparam logic [2:0] ERR_NON_HEX  = 3'd3;
  localparam logic [2:0] ERR_NO_LOW   = 3'd4;
  localparam logic [2:0] ERR_NOT_LOW  = 3'd5;
  localparam logic [2:0] ERR_LONE_LOW = 3'd6;
  localparam logic [2:0] ERR_UNTERM   = 3'd7;

  // One decoded command: a code point with its UTF-8 length minus one, or a
  // string end, or an error. A raw pass-through byte is a one-byte command.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [1:0]  len;
    logic [20:0] cp;
  } cmd_t;

endpackage
`default_nettype wire

@@ src/jsu_if.sv @@
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_string;
  logic       end_of_source;

  modport source (output valid, output in_byte, output start_string,
                  output end_of_source, input ready);
  modport sink (input valid, input in_byte, input start_string,
                input end_of_source, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] item_kind;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output item_kind,
                  output error_code, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input item_kind,
                input error_code, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ src/json_string_unescape_utf8_top.sv @@
// Channel   Dir   Payload                                   Handshake
// in_ch     in    in_byte, start_string, end_of_source      valid / ready
// out_ch    out   out_byte, item_kind, error_code,          valid / ready
//                 last_of_run
//
// The front decoder takes one input item per cycle while the command queue
// has room and writes any command it makes into the queue at the accepting
// edge; that item's first result shows once the back end has registered the
// command. The back end sends one result per cycle while out_ch is ready,
// so a code point of n UTF-8 bytes gives n results; the queue of QUEUE_DEPTH
// commands absorbs bursts. Synchronous active-low reset idles the decoder.
// Either side may stall without stalling the other until the queue fills.
`default_nettype none
module json_string_unescape_utf8_top
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.in_byte),
    .start_string  (in_ch.start_string),
    .end_of_source (in_ch.end_of_source),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push && in_ch.valid && in_ch.ready),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .item_kind   (out_ch.item_kind),
    .error_code  (out_ch.error_code),
    .last_of_run (out_ch.last_of_run)
  );

  a_err_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.item_kind == KIND_ERR) == (out_ch.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  a_flag_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.item_kind != KIND_DATA) |-> out_ch.last_of_run)
    else $error("end or error result not marked last");

  a_multi_byte_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.item_kind == KIND_DATA && !out_ch.last_of_run)
      |-> out_ch.out_byte[7])
    else $error("non-final byte of a sequence is not a UTF-8 lead or continuation");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ch.ready)
    else $error("input accepted while command queue is full");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result presented right after reset");

endmodule
`default_nettype wire

@@ src/jsu_front.sv @@
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_string,
  input  wire logic       end_of_source,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            push_cmd
);

  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_TEXT    = 4'd1;
  localparam logic [3:0] MODE_ESC     = 4'd2;
  localparam logic [3:0] MODE_HI0     = 4'd3;
  localparam logic [3:0] MODE_HI1     = 4'd4;
  localparam logic [3:0] MODE_HI2     = 4'd5;
  localparam logic [3:0] MODE_HI3     = 4'd6;
  localparam logic [3:0] MODE_WANT_BS = 4'd7;
  localparam logic [3:0] MODE_WANT_U  = 4'd8;
  localparam logic [3:0] MODE_LO0     = 4'd9;
  localparam logic [3:0] MODE_LO1     = 4'd10;
  localparam logic [3:0] MODE_LO2     = 4'd11;
  localparam logic [3:0] MODE_LO3     = 4'd12;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  logic [3:0]  mode_r, mode_nxt, mode_s;
  logic [15:0] acc_r, acc_nxt, acc_s;
  logic [9:0]  hs_r, hs_nxt, hs_s;
  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] hex_v;
  logic [20:0] pair_cp;

  function automatic cmd_t data_cmd(input logic [20:0] cp);
    cmd_t c;
    c.kind = KIND_DATA;
    c.err  = ERR_NONE;
    c.cp   = cp;
    if (cp < 21'h80) begin
      c.len = 2'd0;
    end else if (cp < 21'h800) begin
      c.len = 2'd1;
    end else if (cp < 21'h10000) begin
      c.len = 2'd2;
    end else begin
      c.len = 2'd3;
    end
    return c;
  endfunction

  function automatic cmd_t flag_cmd(input logic [1:0] kind, input logic [2:0] err);
    cmd_t c;
    c.kind = kind;
    c.err  = err;
    c.len  = 2'd0;
    c.cp   = '0;
    return c;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign mode_s = start_string ? MODE_TEXT : mode_r;
  assign acc_s  = start_string ? 16'h0 : acc_r;
  assign hs_s   = start_string ? 10'h0 : hs_r;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'h0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_d = in_byte[3:0];
    end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_d = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_v   = {acc_s[11:0], hex_d};
  assign pair_cp = 21'h10000 + {1'b0, hs_s, hex_v[9:0]};

  always_comb begin
    mode_nxt = mode_s;
    acc_nxt  = acc_s;
    hs_nxt   = hs_s;
    push     = 1'b0;
    push_cmd = flag_cmd(KIND_DATA, ERR_NONE);
    if (end_of_source) begin
      mode_nxt = MODE_IDLE;
      if (mode_s != MODE_IDLE) begin
        push = 1'b1;
        push_cmd = flag_cmd(KIND_ERR, (mode_s == MODE_WANT_BS || mode_s == MODE_WANT_U) ?
                            ERR_NO_LOW : ERR_UNTERM);
      end
    end else begin
      case (mode_s)
        MODE_TEXT: begin
          if (in_byte == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            push = 1'b1;
            push_cmd = flag_cmd(KIND_END, ERR_NONE);
          end else if (in_byte == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end else if (in_byte < 8'h20) begin
            mode_nxt = MODE_IDLE;
            push = 1'b1;
            push_cmd = flag_cmd(KIND_ERR, ERR_CTRL);
          end else begin
            push = 1'b1;
            push_cmd = flag_cmd(KIND_DATA, ERR_NONE);
            push_cmd.cp = {13'h0, in_byte};
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_TEXT;
          push = 1'b1;
          push_cmd = flag_cmd(KIND_DATA, ERR_NONE);
          case (in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: push_cmd.cp = {13'h0, in_byte};
            CH_B: push_cmd.cp = 21'h08;
            CH_F: push_cmd.cp = 21'h0C;
            CH_N: push_cmd.cp = 21'h0A;
            CH_R: push_cmd.cp = 21'h0D;
            CH_T: push_cmd.cp = 21'h09;
            CH_U: begin
              push = 1'b0;
              acc_nxt = 16'h0;
              mode_nxt = MODE_HI0;
            end
            default: begin
              mode_nxt = MODE_IDLE;
              push_cmd = flag_cmd(KIND_ERR, ERR_BAD_ESC);
            end
          endcase
        end
        MODE_WANT_BS: begin
          if (in_byte != CH_BSL) begin
            mode_nxt = MODE_IDLE;
            push = 1'b1;
            push_cmd = flag_cmd(KIND_ERR, ERR_NO_LOW);
          end else begin
            mode_nxt = MODE_WANT_U;
          end
        end
        MODE_WANT_U: begin
          if (in_byte != CH_U) begin
            mode_nxt = MODE_IDLE;
            push = 1'b1;
            push_cmd = flag_cmd(KIND_ERR, ERR_NO_LOW);
          end else begin
            acc_nxt = 16'h0;
            mode_nxt = MODE_LO0;
          end
        end
        MODE_HI0, MODE_HI1, MODE_HI2, MODE_HI3,
        MODE_LO0, MODE_LO1, MODE_LO2, MODE_LO3: begin
          if (!hex_ok) begin
            mode_nxt = MODE_IDLE;
            push = 1'b1;
            push_cmd = flag_cmd(KIND_ERR, ERR_NON_HEX);
          end else begin
            acc_nxt = hex_v;
            if (mode_s == MODE_HI3) begin
              if (hex_v inside {[16'hD800:16'hDBFF]}) begin
                hs_nxt = hex_v[9:0];
                mode_nxt = MODE_WANT_BS;
              end else if (hex_v inside {[16'hDC00:16'hDFFF]}) begin
                mode_nxt = MODE_IDLE;
                push = 1'b1;
                push_cmd = flag_cmd(KIND_ERR, ERR_LONE_LOW);
              end else begin
                mode_nxt = MODE_TEXT;
                push = 1'b1;
                push_cmd = data_cmd({5'h0, hex_v});
              end
            end else if (mode_s == MODE_LO3) begin
              push = 1'b1;
              if (hex_v inside {[16'hDC00:16'hDFFF]}) begin
                mode_nxt = MODE_TEXT;
                push_cmd = data_cmd(pair_cp);
              end else begin
                mode_nxt = MODE_IDLE;
                push_cmd = flag_cmd(KIND_ERR, ERR_NOT_LOW);
              end
            end else begin
              mode_nxt = mode_s + 4'd1;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= 16'h0;
      hs_r   <= 10'h0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/jsu_queue.sv @@
`default_nettype none
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = count_r == CNT_FULL;
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/jsu_back.sv @@
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire cmd_t       head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      item_kind,
  output logic [2:0]      error_code,
  output logic            last_of_run
);

  cmd_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       last;
  logic       take;

  assign last = idx_r == cur_r.len;
  assign take = cur_valid_r && out_ready;
  assign pop  = head_valid && (!cur_valid_r || (take && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (take) begin
      if (last) begin
        cur_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_cmd;
    end
  end

  always_comb begin
    out_byte = 8'h00;
    case (cur_r.len)
      2'd0: out_byte = cur_r.cp[7:0];
      2'd1: begin
        case (idx_r)
          2'd0:    out_byte = {3'b110, cur_r.cp[10:6]};
          default: out_byte = {2'b10, cur_r.cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx_r)
          2'd0:    out_byte = {4'b1110, cur_r.cp[15:12]};
          2'd1:    out_byte = {2'b10, cur_r.cp[11:6]};
          default: out_byte = {2'b10, cur_r.cp[5:0]};
        endcase
      end
      default: begin
        case (idx_r)
          2'd0:    out_byte = {5'b11110, cur_r.cp[20:18]};
          2'd1:    out_byte = {2'b10, cur_r.cp[17:12]};
          2'd2:    out_byte = {2'b10, cur_r.cp[11:6]};
          default: out_byte = {2'b10, cur_r.cp[5:0]};
        endcase
      end
    endcase
  end

  assign out_valid   = cur_valid_r;
  assign item_kind   = cur_r.kind;
  assign error_code  = cur_r.err;
  assign last_of_run = last;

endmodule
`default_nettype wire
